>>> rtl/core/crma_pkg.sv
// ----------------------------------------------------------------------------
// Checked region memory access package
// Shared constants, codes and types for the checked region memory.
// ----------------------------------------------------------------------------
package crma_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int MEM_ROWS  = MEM_BYTES / 8;
    localparam int OFF_AW    = $clog2(MEM_BYTES);
    localparam int ROW_AW    = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;
    localparam int CMP_W     = ((OFF_AW + 1 > 13) ? OFF_AW + 1 : 13) + 1;
    localparam int LANES     = 8;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_MISALIGNED = 2'd1,
        ST_RANGE      = 2'd2,
        ST_PERM       = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_REGION_BASE  = 2'd0,
        CFG_REGION_BYTES = 2'd1,
        CFG_ALLOW_READ   = 2'd2,
        CFG_ALLOW_WRITE  = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [63:0] region_base;
        logic [12:0] region_bytes;
        logic        allow_read;
        logic        allow_write;
    } region_cfg_t;

    typedef struct packed {
        status_t                         status;
        logic                            read_ok;
        logic [2:0]                      lane_off;
        logic [LANES-1:0]                lane_en;
        logic [LANES-1:0]                lane_we;
        logic [LANES-1:0][ROW_AW-1:0]    lane_row;
        logic [LANES-1:0][7:0]           lane_wdata;
    } access_ctl_t;

endpackage

>>> rtl/core/crma_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module crma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/crma_cfg.sv
// ----------------------------------------------------------------------------
// Region configuration registers
// Holds the region base, size and access permissions.
// ----------------------------------------------------------------------------
module crma_cfg
    import crma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output region_cfg_t region
);

    region_cfg_t region_reg;
    region_cfg_t region_next;

    always_comb
    begin
        region_next = region_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_REGION_BASE:  region_next.region_base  = cfg_data;
                CFG_REGION_BYTES: region_next.region_bytes = cfg_data[12:0];
                CFG_ALLOW_READ:   region_next.allow_read   = cfg_data[0];
                CFG_ALLOW_WRITE:  region_next.allow_write  = cfg_data[0];
                default:          region_next = region_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg.region_base  <= 64'd0;
            region_reg.region_bytes <= 13'd4096;
            region_reg.allow_read   <= 1'b1;
            region_reg.allow_write  <= 1'b1;
        end
        else
        begin
            region_reg <= region_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign region    = region_reg;

endmodule

>>> rtl/core/crma_check.sv
// ----------------------------------------------------------------------------
// Access checker and lane steering
// Runs the alignment, range and permission checks and steers bytes to lanes.
// ----------------------------------------------------------------------------
module crma_check
    import crma_pkg::*;
(
    input  region_cfg_t region,
    input  logic        opcode,
    input  logic [1:0]  access_size,
    input  logic [63:0] address,
    input  logic [63:0] write_data,
    output access_ctl_t ctl
);

    logic [3:0]            nbytes;
    logic [2:0]            align_mask;
    logic                  misaligned;
    logic [64:0]           diff;
    logic                  borrow;
    logic [63:0]           off;
    logic [CMP_W-1:0]      span;
    logic [CMP_W-1:0]      end_sum;
    logic                  range_bad;
    logic                  perm_bad;
    logic                  access_ok;
    logic [ROW_AW-1:0]     row_base;
    logic [2:0]            lane_off;
    logic [2:0]            byte_idx [LANES];

    always_comb
    begin
        nbytes     = 4'd1 << access_size;
        align_mask = 3'(nbytes - 4'd1);
        misaligned = (address[2:0] & align_mask) != 3'd0;

        diff   = {1'b0, address} - {1'b0, region.region_base};
        borrow = diff[64];
        off    = diff[63:0];

        if (CMP_W'(region.region_bytes) > CMP_W'(MEM_BYTES))
        begin
            span = CMP_W'(MEM_BYTES);
        end
        else
        begin
            span = CMP_W'(region.region_bytes);
        end

        end_sum   = CMP_W'(off[OFF_AW-1:0]) + CMP_W'(nbytes);
        range_bad = borrow || (off[63:OFF_AW] != '0) || (end_sum > span);
        perm_bad  = (opcode == OP_WRITE) ? !region.allow_write : !region.allow_read;

        priority if (misaligned)
        begin
            ctl.status = ST_MISALIGNED;
        end
        else if (range_bad)
        begin
            ctl.status = ST_RANGE;
        end
        else if (perm_bad)
        begin
            ctl.status = ST_PERM;
        end
        else
        begin
            ctl.status = ST_OK;
        end

        access_ok   = (ctl.status == ST_OK);
        ctl.read_ok = access_ok && (opcode == OP_READ);
        lane_off    = off[2:0];
        row_base    = ROW_AW'(off[OFF_AW-1:0] >> 3);
        ctl.lane_off = lane_off;

        for (int l = 0; l < LANES; l++)
        begin
            byte_idx[l]       = 3'(l) - lane_off;
            ctl.lane_en[l]    = access_ok && ({1'b0, byte_idx[l]} < nbytes);
            ctl.lane_we[l]    = ctl.lane_en[l] && (opcode == OP_WRITE);
            ctl.lane_row[l]   = row_base + ROW_AW'(3'(l) < lane_off);
            ctl.lane_wdata[l] = write_data[byte_idx[l]*8 +: 8];
        end
    end

endmodule

>>> rtl/core/checked_region_memory_access.sv
// ----------------------------------------------------------------------------
// Checked region memory access
// One address region backed by a byte store, with alignment, range and
// permission checks on every read or write.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while it is not stalled. The accepted
// request is registered, then checked and sent to the store, and the store's
// registered read data is realigned into the output register that holds the
// response. The store is eight byte-wide RAMs of MEM_BYTES/8 rows, one per
// byte lane, so any access of up to eight bytes touches each lane once. After
// reset the store is cleared one row per cycle; no request is accepted until
// every row is clear. A stalled response holds the whole pipeline.
module checked_region_memory_access
    import crma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        opcode,
    input  logic [1:0]  access_size,
    input  logic [63:0] address,
    input  logic [63:0] write_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [63:0] read_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    region_cfg_t      region;
    access_ctl_t      ctl;

    logic [ROW_AW:0]  clr_cnt_reg;
    logic [ROW_AW:0]  clr_cnt_next;
    logic             clearing;
    logic             advance;
    logic             req_accept;

    logic             s1_valid_reg;
    logic             s1_opcode_reg;
    logic [1:0]       s1_size_reg;
    logic [63:0]      s1_address_reg;
    logic [63:0]      s1_wdata_reg;

    logic             s2_valid_reg;
    status_t          s2_status_reg;
    logic             s2_read_ok_reg;
    logic [2:0]       s2_lane_off_reg;
    logic [3:0]       s2_nbytes_reg;

    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [63:0]      out_data_reg;
    logic [63:0]      out_data_next;

    logic [LANES-1:0][7:0] lane_rdata;

    crma_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .region    (region)
    );

    crma_check u_check (
        .region      (region),
        .opcode      (s1_opcode_reg),
        .access_size (s1_size_reg),
        .address     (s1_address_reg),
        .write_data  (s1_wdata_reg),
        .ctl         (ctl)
    );

    assign clearing   = (clr_cnt_reg != (ROW_AW + 1)'(MEM_ROWS));
    assign advance    = !(out_valid_reg && rsp_stall);
    assign req_stall  = clearing || !advance;
    assign req_accept = req_valid && !req_stall;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic              lane_en;
        logic              lane_we;
        logic [ROW_AW-1:0] lane_addr;
        logic [7:0]        lane_wdata;

        always_comb
        begin
            if (clearing)
            begin
                lane_en    = 1'b1;
                lane_we    = 1'b1;
                lane_addr  = clr_cnt_reg[ROW_AW-1:0];
                lane_wdata = 8'd0;
            end
            else
            begin
                lane_en    = advance && s1_valid_reg && ctl.lane_en[l];
                lane_we    = ctl.lane_we[l];
                lane_addr  = ctl.lane_row[l];
                lane_wdata = ctl.lane_wdata[l];
            end
        end

        crma_ram #(
            .WIDTH (8),
            .DEPTH (MEM_ROWS)
        ) u_ram (
            .clk   (clk),
            .en    (lane_en),
            .we    (lane_we),
            .addr  (lane_addr),
            .wdata (lane_wdata),
            .rdata (lane_rdata[l])
        );
    end

    always_comb
    begin
        clr_cnt_next = clearing ? clr_cnt_reg + (ROW_AW + 1)'(1) : clr_cnt_reg;

        for (int j = 0; j < LANES; j++)
        begin
            if (s2_read_ok_reg && (4'(j) < s2_nbytes_reg))
            begin
                out_data_next[j*8 +: 8] = lane_rdata[3'(j) + s2_lane_off_reg];
            end
            else
            begin
                out_data_next[j*8 +: 8] = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            if (advance)
            begin
                s1_valid_reg  <= req_accept;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_opcode_reg  <= opcode;
            s1_size_reg    <= access_size;
            s1_address_reg <= address;
            s1_wdata_reg   <= write_data;
        end
        if (advance)
        begin
            s2_status_reg   <= ctl.status;
            s2_read_ok_reg  <= ctl.read_ok;
            s2_lane_off_reg <= ctl.lane_off;
            s2_nbytes_reg   <= 4'd1 << s1_size_reg;
            out_status_reg  <= s2_status_reg;
            out_data_reg    <= out_data_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign read_data = out_data_reg;

endmodule
